// ===== rtl/core/irpm_pkg.sv =====
package irpm_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_US    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_US      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_US = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INVERT_INPUT = 2'd3;

  // reset values of the registers
  localparam logic [7:0]  FILTER_US_RST    = 8'd50;
  localparam logic [15:0] IDLE_US_RST      = 16'd10000;
  localparam logic [6:0]  TICKS_PER_US_RST = 7'd1;

  // field widths
  localparam int unsigned DUR_W   = 15;
  localparam int unsigned TICKS_W = 32;
  localparam int unsigned RATE_W  = 7;
  localparam int unsigned FT_W    = 15;

  // divider: quotient bits produced per cycle
  localparam int unsigned DIV_BITS  = 4;
  localparam int unsigned DIV_STEPS = TICKS_W / DIV_BITS;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [TICKS_W-1:0] I32_MAX = 32'h7FFF_FFFF;
  localparam logic [TICKS_W-1:0] U32_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [7:0]        filter_us;
    logic [15:0]       idle_us;
    logic [RATE_W-1:0] tick_rate;   // never zero
    logic              invert;
  } cfg_t;

  // one command from the front to the back
  typedef struct packed {
    logic [TICKS_W-1:0] ticks;     // run ticks, or idle microseconds for a terminator
    logic               level;
    logic               term;
  } cmd_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_HALF_A,
    F_HALF_B,
    F_FLUSH,
    F_TERM
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DIV,
    B_OUT
  } back_state_t;

endpackage

// ===== rtl/core/irpm_queue.sv =====
module irpm_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push_valid,
  output logic          push_ready,
  input  irpm_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output irpm_pkg::cmd_t pop_cmd
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  irpm_pkg::cmd_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_ready && pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue fill count beyond depth");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == CNT_W'($past(count_r) + 1'b1)))
    else $error("queue push lost");

endmodule

// ===== rtl/core/irpm_front.sv =====
module irpm_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  irpm_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_level_a,
  input  logic [irpm_pkg::DUR_W-1:0]    in_duration_a,
  input  logic                          in_level_b,
  input  logic [irpm_pkg::DUR_W-1:0]    in_duration_b,
  input  logic                          in_last_symbol,
  output logic                          push_valid,
  input  logic                          push_ready,
  output irpm_pkg::cmd_t                push_cmd
);

  irpm_pkg::front_state_t state_r, state_nxt;

  logic                             run_level_r, run_level_nxt;
  logic [irpm_pkg::TICKS_W-1:0]     run_ticks_r, run_ticks_nxt;
  logic                             idle_level_r, idle_level_nxt;
  logic                             stopped_r, stopped_nxt;
  logic                             any_r, any_nxt;

  // latched word
  logic                             la_r, lb_r, last_r;
  logic [irpm_pkg::DUR_W-1:0]       da_r, db_r;

  logic [irpm_pkg::FT_W-1:0]        ft;
  logic                             h_level;
  logic [irpm_pkg::DUR_W-1:0]       h_dur;
  logic [irpm_pkg::TICKS_W:0]       sum;
  logic                             run_passes;
  logic                             step_done;
  logic                             accept;

  assign ft         = irpm_pkg::FT_W'(cfg.filter_us) * irpm_pkg::FT_W'(cfg.tick_rate);
  assign h_level    = (state_r == irpm_pkg::F_HALF_B) ? lb_r : la_r;
  assign h_dur      = (state_r == irpm_pkg::F_HALF_B) ? db_r : da_r;
  assign sum        = {1'b0, run_ticks_r} + (irpm_pkg::TICKS_W + 1)'(h_dur);
  assign run_passes = (run_ticks_r >= irpm_pkg::TICKS_W'(ft));
  assign in_ready   = (state_r == irpm_pkg::F_IDLE);
  assign accept     = in_valid && in_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      irpm_pkg::F_IDLE:   if (in_valid) state_nxt = irpm_pkg::F_HALF_A;
      irpm_pkg::F_HALF_A: if (step_done) state_nxt = irpm_pkg::F_HALF_B;
      irpm_pkg::F_HALF_B: begin
        if (step_done) state_nxt = last_r ? irpm_pkg::F_FLUSH : irpm_pkg::F_IDLE;
      end
      irpm_pkg::F_FLUSH:  if (step_done) state_nxt = irpm_pkg::F_TERM;
      irpm_pkg::F_TERM:   if (step_done) state_nxt = irpm_pkg::F_IDLE;
      default:            state_nxt = irpm_pkg::F_IDLE;
    endcase
  end

  // run bookkeeping and commands
  always_comb begin
    run_level_nxt  = run_level_r;
    run_ticks_nxt  = run_ticks_r;
    idle_level_nxt = idle_level_r;
    stopped_nxt    = stopped_r;
    any_nxt        = any_r;
    push_valid     = 1'b0;
    push_cmd       = '0;
    step_done      = 1'b1;
    case (state_r)
      irpm_pkg::F_HALF_A, irpm_pkg::F_HALF_B: begin
        if (!stopped_r) begin
          if (h_dur == '0) begin
            stopped_nxt = 1'b1;
          end else if (h_level == run_level_r || h_dur < ft) begin
            run_ticks_nxt  = sum[irpm_pkg::TICKS_W] ? irpm_pkg::U32_MAX
                                                    : sum[irpm_pkg::TICKS_W-1:0];
            idle_level_nxt = ~h_level;
          end else begin
            // new level closes the run
            push_valid = run_passes;
            push_cmd   = '{ticks: run_ticks_r, level: run_level_r, term: 1'b0};
            if (run_passes && !push_ready) begin
              step_done = 1'b0;
            end else begin
              run_level_nxt  = h_level;
              run_ticks_nxt  = irpm_pkg::TICKS_W'(h_dur);
              idle_level_nxt = ~h_level;
              if (run_passes) any_nxt = 1'b1;
            end
          end
        end
      end
      irpm_pkg::F_FLUSH: begin
        if (run_passes && run_level_r != idle_level_r) begin
          push_valid = 1'b1;
          push_cmd   = '{ticks: run_ticks_r, level: run_level_r, term: 1'b0};
          if (push_ready) any_nxt = 1'b1;
          else step_done = 1'b0;
        end
      end
      irpm_pkg::F_TERM: begin
        if (any_r) begin
          push_valid = 1'b1;
          push_cmd   = '{ticks: irpm_pkg::TICKS_W'(cfg.idle_us), level: idle_level_r,
                         term: 1'b1};
          step_done  = push_ready;
        end
        if (step_done) begin
          run_level_nxt  = 1'b0;
          run_ticks_nxt  = '0;
          idle_level_nxt = 1'b0;
          stopped_nxt    = 1'b0;
          any_nxt        = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= irpm_pkg::F_IDLE;
      run_level_r  <= 1'b0;
      run_ticks_r  <= '0;
      idle_level_r <= 1'b0;
      stopped_r    <= 1'b0;
      any_r        <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      run_level_r  <= run_level_nxt;
      run_ticks_r  <= run_ticks_nxt;
      idle_level_r <= idle_level_nxt;
      stopped_r    <= stopped_nxt;
      any_r        <= any_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      la_r   <= in_level_a;
      da_r   <= in_duration_a;
      lb_r   <= in_level_b;
      db_r   <= in_duration_b;
      last_r <= in_last_symbol;
    end
  end

endmodule

// ===== rtl/core/irpm_back.sv =====
module irpm_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  irpm_pkg::cfg_t             cfg,
  input  logic                       pop_valid,
  output logic                       pop_ready,
  input  irpm_pkg::cmd_t             pop_cmd,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [31:0]         out_pulse_us,
  output logic                       out_frame_end
);

  irpm_pkg::back_state_t state_r, state_nxt;

  logic [irpm_pkg::TICKS_W-1:0]   quo_r, quo_nxt;
  logic [irpm_pkg::RATE_W-1:0]    rem_r, rem_nxt;
  logic [irpm_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           lvl_r, lvl_nxt;
  logic signed [31:0]             pulse_r, pulse_nxt;
  logic                           end_r, end_nxt;
  logic [irpm_pkg::TICKS_W-1:0]   div_q;
  logic [irpm_pkg::RATE_W-1:0]    div_r;
  logic                           div_last;

  function automatic logic signed [31:0] make_pulse(input logic [31:0] mag,
                                                    input logic        positive);
    logic [31:0] sat;
    sat = mag[31] ? irpm_pkg::I32_MAX : mag;
    return positive ? $signed(sat) : -$signed(sat);
  endfunction

  // restoring division, several quotient bits per cycle
  always_comb begin : div_comb
    logic [irpm_pkg::RATE_W:0] t;
    div_q = quo_r;
    div_r = rem_r;
    t     = '0;
    for (int i = 0; i < irpm_pkg::DIV_BITS; i++) begin
      t     = {div_r, div_q[irpm_pkg::TICKS_W-1]};
      div_q = {div_q[irpm_pkg::TICKS_W-2:0], 1'b0};
      if (t >= {1'b0, cfg.tick_rate}) begin
        div_r    = irpm_pkg::RATE_W'(t - {1'b0, cfg.tick_rate});
        div_q[0] = 1'b1;
      end else begin
        div_r = t[irpm_pkg::RATE_W-1:0];
      end
    end
  end

  assign div_last = (cnt_r == irpm_pkg::DIV_CNT_W'(irpm_pkg::DIV_STEPS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      irpm_pkg::B_IDLE: begin
        if (pop_valid) state_nxt = pop_cmd.term ? irpm_pkg::B_OUT : irpm_pkg::B_DIV;
      end
      irpm_pkg::B_DIV:  if (div_last) state_nxt = irpm_pkg::B_OUT;
      irpm_pkg::B_OUT:  if (out_ready) state_nxt = irpm_pkg::B_IDLE;
      default:          state_nxt = irpm_pkg::B_IDLE;
    endcase
  end

  // datapath and handshake
  always_comb begin
    pop_ready = (state_r == irpm_pkg::B_IDLE);
    out_valid = (state_r == irpm_pkg::B_OUT);
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    cnt_nxt   = cnt_r;
    lvl_nxt   = lvl_r;
    pulse_nxt = pulse_r;
    end_nxt   = end_r;
    case (state_r)
      irpm_pkg::B_IDLE: begin
        quo_nxt = pop_cmd.ticks;
        rem_nxt = '0;
        cnt_nxt = '0;
        lvl_nxt = pop_cmd.level;
        end_nxt = pop_cmd.term;
        // terminator carries microseconds already
        pulse_nxt = make_pulse(pop_cmd.ticks, pop_cmd.level ^ cfg.invert);
      end
      irpm_pkg::B_DIV: begin
        quo_nxt = div_q;
        rem_nxt = div_r;
        cnt_nxt = irpm_pkg::DIV_CNT_W'(cnt_r + 1'b1);
        if (div_last) pulse_nxt = make_pulse(div_q, lvl_r ^ cfg.invert);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= irpm_pkg::B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r   <= quo_nxt;
    rem_r   <= rem_nxt;
    cnt_r   <= cnt_nxt;
    lvl_r   <= lvl_nxt;
    pulse_r <= pulse_nxt;
    end_r   <= end_nxt;
  end

  assign out_pulse_us  = pulse_r;
  assign out_frame_end = end_r;

  a_term_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_end) |-> (out_pulse_us <= 32'sd65535 &&
                                      out_pulse_us >= -32'sd65535))
    else $error("terminator magnitude out of range");

  a_div_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == irpm_pkg::B_DIV) |=>
      ((state_r == irpm_pkg::B_DIV &&
        cnt_r == irpm_pkg::DIV_CNT_W'($past(cnt_r) + 1'b1)) ||
       state_r == irpm_pkg::B_OUT))
    else $error("divider step count broken");

endmodule

// ===== rtl/core/ir_pulse_run_merger.sv =====
// a closed run passes from the front through the command queue, the divider and the output register
// front: walks half a, half b, after the last word flush and terminator; one word at a time
// back: a run result passes the divider (4 quotient bits per step); a terminator skips it
// a command queue between front and back lets the front run ahead of the divider
// reset: synchronous, active low; clears run state, queue and handshakes
// reset also restores the registers: filter 50, idle 10000, ticks per us 1, no inversion
module ir_pulse_run_merger #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [irpm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [irpm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // symbol words in
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_level_a,
  input  logic [irpm_pkg::DUR_W-1:0]        in_duration_a,
  input  logic                              in_level_b,
  input  logic [irpm_pkg::DUR_W-1:0]        in_duration_b,
  input  logic                              in_last_symbol,
  // pulse words out
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [31:0]                out_pulse_us,
  output logic                              out_frame_end
);

  // configuration registers
  logic [7:0]                  filter_us_r;
  logic [15:0]                 idle_us_r;
  logic [irpm_pkg::RATE_W-1:0] ticks_per_us_r;
  logic                        invert_r;
  irpm_pkg::cfg_t              cfg;

  // front to queue, queue to back
  logic           push_valid, push_ready;
  irpm_pkg::cmd_t push_cmd;
  logic           pop_valid, pop_ready;
  irpm_pkg::cmd_t pop_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_us_r    <= irpm_pkg::FILTER_US_RST;
      idle_us_r      <= irpm_pkg::IDLE_US_RST;
      ticks_per_us_r <= irpm_pkg::TICKS_PER_US_RST;
      invert_r       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        irpm_pkg::CFG_FILTER_US:    filter_us_r    <= cfg_wdata[7:0];
        irpm_pkg::CFG_IDLE_US:      idle_us_r      <= cfg_wdata[15:0];
        irpm_pkg::CFG_TICKS_PER_US: ticks_per_us_r <= cfg_wdata[irpm_pkg::RATE_W-1:0];
        irpm_pkg::CFG_INVERT_INPUT: invert_r       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // a tick rate of zero behaves as one tick per microsecond
  assign cfg.filter_us = filter_us_r;
  assign cfg.idle_us   = idle_us_r;
  assign cfg.tick_rate = (ticks_per_us_r == '0) ? irpm_pkg::RATE_W'(1) : ticks_per_us_r;
  assign cfg.invert    = invert_r;

  // front: takes a word, walks its halves, keeps the open run, issues run and
  // terminator commands
  irpm_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_level_a     (in_level_a),
    .in_duration_a  (in_duration_a),
    .in_level_b     (in_level_b),
    .in_duration_b  (in_duration_b),
    .in_last_symbol (in_last_symbol),
    .push_valid     (push_valid),
    .push_ready     (push_ready),
    .push_cmd       (push_cmd)
  );

  // short command queue so either side can stall on its own
  irpm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  // back: tick to microsecond division, clamp, sign, output register
  irpm_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_cmd       (pop_cmd),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_pulse_us  (out_pulse_us),
    .out_frame_end (out_frame_end)
  );

endmodule
